FILE: rtl/core/sorted_priority_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the sorted priority queue RTL
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int RANK_WIDTH_DEF  = 16;

	localparam int VALUE_W     = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int RANK_PORT_W = 16;
	localparam int OCC_W       = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		SPQ_IDLE,
		SPQ_SETUP,
		SPQ_INS_RD,
		SPQ_INS_CMP,
		SPQ_INS_PUT,
		SPQ_HEAD
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_store #(
	parameter int DEPTH  = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int WORD_W = spq_pkg::VALUE_W + spq_pkg::RANK_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire spq_pkg::mem_ctl_t        ctl,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WORD_W-1:0]        wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WORD_W-1:0]             rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted by rank in a circular entry memory.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  command  | start / busy       | func, item_value, item_rank
//  result   | done (1-cycle)     | status, head_value, occupancy
//
// One command at a time; busy is high from the beat until its result is out.
// Remove or peek with entries held pass through setup and a head read; refused,
// empty-queue and unused ops finish in setup. done follows for one cycle.
// Insert into an empty queue finishes in setup. Otherwise setup, a first read,
// compare-and-move steps, and a put if the head moves; the tail walk moves one entry per memory cycle.
// Remove only advances the head pointer. Reset clears count and head pointer.
// The result side cannot stall; a new command may be taken while done is up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int RANK_WIDTH  = spq_pkg::RANK_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [spq_pkg::FUNC_W-1:0]             func,
	input  wire logic signed [spq_pkg::VALUE_W-1:0]     item_value,
	input  wire logic [spq_pkg::RANK_PORT_W-1:0]        item_rank,
	output logic                                        done,
	output logic [spq_pkg::STATUS_W-1:0]                status,
	output logic signed [spq_pkg::VALUE_W-1:0]          head_value,
	output logic [spq_pkg::OCC_W-1:0]                   occupancy
);

	`include "sorted_priority_queue_top_macros.svh"

	localparam int AW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int SW     = AW + 1;
	localparam int WORD_W = spq_pkg::VALUE_W + RANK_WIDTH;

	spq_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [CW-1:0] idx_q, idx_d;

	logic [spq_pkg::FUNC_W-1:0]  func_q;
	logic [spq_pkg::VALUE_W-1:0] value_q;
	logic [RANK_WIDTH-1:0]       rank_q;

	logic                          done_q;
	logic [spq_pkg::STATUS_W-1:0]  status_q;
	logic [spq_pkg::VALUE_W-1:0]   head_value_q;
	logic [spq_pkg::OCC_W-1:0]     occupancy_q;

	logic                          res_en;
	logic [spq_pkg::STATUS_W-1:0]  res_status;
	logic [spq_pkg::VALUE_W-1:0]   res_value;

	spq_pkg::mem_ctl_t     mem_ctl;
	logic [AW-1:0]         mem_wr_addr;
	logic [WORD_W-1:0]     mem_wr_data;
	logic [AW-1:0]         mem_rd_addr;
	logic [WORD_W-1:0]     mem_rd_data;

	logic [WORD_W-1:0]           new_word;
	logic [RANK_WIDTH-1:0]       rd_rank;
	logic [spq_pkg::VALUE_W-1:0] rd_value;
	logic                        rank_ge;
	logic                        rank_eq;
	logic                        move;
	logic [SW-1:0]               tail_sum;
	logic [AW-1:0]               tail;

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		ptr_prev = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	spq_store #(
		.DEPTH  (QUEUE_DEPTH),
		.WORD_W (WORD_W)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign busy       = (state_q != spq_pkg::SPQ_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign head_value = head_value_q;
	assign occupancy  = occupancy_q;

	assign new_word = {value_q, rank_q};
	assign rd_rank  = mem_rd_data[RANK_WIDTH-1:0];
	assign rd_value = mem_rd_data[RANK_WIDTH +: spq_pkg::VALUE_W];

	// the comparators of the walk
	assign rank_ge = (rd_rank >= rank_q);
	assign rank_eq = (rd_rank == rank_q);
	// head moves only on strictly larger rank, later slots on larger or equal
	assign move    = (idx_q == CW'(1)) ? (rank_ge && !rank_eq) : rank_ge;

	// tail slot = head + count, wrapped; count is below depth here
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                 : AW'(tail_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::SPQ_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			done_q  <= res_en;
		end
	end

	always_ff @(posedge clk) begin
		wr_ptr_q <= wr_ptr_d;
		rd_ptr_q <= rd_ptr_d;
		idx_q    <= idx_d;
		if (state_q == spq_pkg::SPQ_IDLE && start) begin
			func_q  <= func;
			value_q <= item_value;
			rank_q  <= RANK_WIDTH'(item_rank);
		end
		if (res_en) begin
			status_q     <= res_status;
			head_value_q <= res_value;
			occupancy_q  <= spq_pkg::OCC_W'(count_d);
		end
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		wr_ptr_d    = wr_ptr_q;
		rd_ptr_d    = rd_ptr_q;
		idx_d       = idx_q;
		mem_ctl     = '0;
		mem_wr_addr = wr_ptr_q;
		mem_wr_data = new_word;
		mem_rd_addr = rd_ptr_q;
		res_en      = 1'b0;
		res_status  = spq_pkg::ST_OK;
		res_value   = '0;

		unique case (state_q)
			spq_pkg::SPQ_IDLE: begin
				if (start) begin
					state_d = spq_pkg::SPQ_SETUP;
				end
			end
			spq_pkg::SPQ_SETUP: begin
				priority if (func_q == spq_pkg::FN_INSERT) begin
					priority if (count_q == CW'(QUEUE_DEPTH)) begin
						res_en     = 1'b1;
						res_status = spq_pkg::ST_FULL;
						state_d    = spq_pkg::SPQ_IDLE;
					end else if (count_q == '0) begin
						mem_ctl.wr_en = 1'b1;
						mem_wr_addr   = head_q;
						count_d       = count_q + CW'(1);
						res_en        = 1'b1;
						state_d       = spq_pkg::SPQ_IDLE;
					end else begin
						wr_ptr_d = tail;
						rd_ptr_d = ptr_prev(tail);
						idx_d    = count_q;
						state_d  = spq_pkg::SPQ_INS_RD;
					end
				end else if (func_q == spq_pkg::FN_REMOVE || func_q == spq_pkg::FN_PEEK) begin
					if (count_q == '0) begin
						res_en     = 1'b1;
						res_status = spq_pkg::ST_EMPTY;
						state_d    = spq_pkg::SPQ_IDLE;
					end else begin
						mem_ctl.rd_en = 1'b1;
						mem_rd_addr   = head_q;
						state_d       = spq_pkg::SPQ_HEAD;
					end
				end else begin
					res_en  = 1'b1;
					state_d = spq_pkg::SPQ_IDLE;
				end
			end
			spq_pkg::SPQ_INS_RD: begin
				mem_ctl.rd_en = 1'b1;
				rd_ptr_d      = ptr_prev(rd_ptr_q);
				state_d       = spq_pkg::SPQ_INS_CMP;
			end
			spq_pkg::SPQ_INS_CMP: begin
				// read data is the entry just below the open slot
				mem_ctl.wr_en = 1'b1;
				if (move) begin
					mem_wr_data   = mem_rd_data;
					wr_ptr_d      = ptr_prev(wr_ptr_q);
					idx_d         = idx_q - CW'(1);
					mem_ctl.rd_en = 1'b1;
					rd_ptr_d      = ptr_prev(rd_ptr_q);
					if (idx_q == CW'(1)) begin
						state_d = spq_pkg::SPQ_INS_PUT;
					end
				end else begin
					count_d = count_q + CW'(1);
					res_en  = 1'b1;
					state_d = spq_pkg::SPQ_IDLE;
				end
			end
			spq_pkg::SPQ_INS_PUT: begin
				mem_ctl.wr_en = 1'b1;
				count_d       = count_q + CW'(1);
				res_en        = 1'b1;
				state_d       = spq_pkg::SPQ_IDLE;
			end
			spq_pkg::SPQ_HEAD: begin
				res_en    = 1'b1;
				res_value = rd_value;
				if (func_q == spq_pkg::FN_REMOVE) begin
					head_d  = ptr_next(head_q);
					count_d = count_q - CW'(1);
				end
				state_d = spq_pkg::SPQ_IDLE;
			end
			default: begin
				state_d = spq_pkg::SPQ_IDLE;
			end
		endcase
	end

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH), "entry count above depth")
	`SPQ_ASSERT_NEXT(a_busy_after_beat, start && !busy, busy, "command beat did not raise busy")
	`SPQ_ASSERT_NOW(a_done_after_work, done_q, $past(state_q) != spq_pkg::SPQ_IDLE, "done without work")
	`SPQ_ASSERT_NOW(a_no_idle_write, state_q == spq_pkg::SPQ_IDLE, !mem_ctl.wr_en, "write while idle")
	`SPQ_ASSERT_NOW(a_full_status, done_q && status_q == spq_pkg::ST_FULL, count_q == CW'(QUEUE_DEPTH), "full status below depth")

endmodule

`default_nettype wire

FILE: verif/sorted_priority_queue_top_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test
// Self-checking bench for the sorted priority queue. A rank-ordered mirror
// predicts status, head data and occupancy for every accepted command; the
// result monitor compares each done strobe against the oldest prediction.
// Directed corner cases come first, then bursts that fill, drain and mix.
// ----------------------------------------------------------------------------

module sorted_priority_queue_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
	localparam int RANK_WIDTH   = RANK_WIDTH_DEF;
	localparam int CMD_TARGET   = 950;
	localparam int LIMIT_CYCLES = 500000;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam logic [RANK_PORT_W-1:0] RANK_MASK =
		RANK_PORT_W'((64'd1 << RANK_WIDTH) - 64'd1);

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} burst_mix_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  head_value;
		logic [OCC_W-1:0]    occupancy;
	} queue_reply_t;

	// mirror of the sorted store plus the replies still owed by the block
	class rank_queue_mirror;
		logic [VALUE_W-1:0]     stored_value[QUEUE_DEPTH];
		logic [RANK_PORT_W-1:0] stored_rank[QUEUE_DEPTH];
		int                     held;
		queue_reply_t           replies_due[$];
		int                     errors;
		int                     n_replies;
		int                     n_full;
		int                     n_empty;
		int                     peak_held;

		function new();
			held = 0;
			errors = 0;
			n_replies = 0;
			n_full = 0;
			n_empty = 0;
			peak_held = 0;
		endfunction

		function void note_command(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] value,
				logic [RANK_PORT_W-1:0] rank_in);
			queue_reply_t r;
			logic [RANK_PORT_W-1:0] rank;
			int pos;
			rank = rank_in & RANK_MASK;
			r.status = ST_OK;
			r.head_value = '0;
			case (fn)
				FN_INSERT: begin
					if (held >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						// head wins only on a strictly larger rank; otherwise
						// first non-head entry with rank >= new rank
						pos = held;
						if (held == 0 || stored_rank[0] > rank) begin
							pos = 0;
						end else begin
							for (int i = held - 1; i >= 1; i--) begin
								if (stored_rank[i] >= rank)
									pos = i;
							end
						end
						for (int i = held; i > pos; i--) begin
							stored_value[i] = stored_value[i-1];
							stored_rank[i] = stored_rank[i-1];
						end
						stored_value[pos] = value;
						stored_rank[pos] = rank;
						held++;
						if (held > peak_held)
							peak_held = held;
					end
				end
				FN_REMOVE, FN_PEEK: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						r.head_value = stored_value[0];
						if (fn == FN_REMOVE) begin
							for (int i = 1; i < held; i++) begin
								stored_value[i-1] = stored_value[i];
								stored_rank[i-1] = stored_rank[i];
							end
							held--;
						end
					end
				end
				default: ;
			endcase
			r.occupancy = OCC_W'(held);
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] hv,
				logic [OCC_W-1:0] occ);
			queue_reply_t r;
			if (replies_due.size() == 0) begin
				$error("result strobe with no command outstanding");
				errors++;
				return;
			end
			r = replies_due.pop_front();
			n_replies++;
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				errors++;
			end
			if (hv !== r.head_value) begin
				$error("head_value: expected %0d, actual %0d",
					$signed(r.head_value), $signed(hv));
				errors++;
			end
			if (occ !== r.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", r.occupancy, occ);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [FUNC_W-1:0]             func;
	logic signed [VALUE_W-1:0]     item_value;
	logic [RANK_PORT_W-1:0]        item_rank;
	logic                          done;
	logic [STATUS_W-1:0]           status;
	logic signed [VALUE_W-1:0]     head_value;
	logic [OCC_W-1:0]              occupancy;

	rank_queue_mirror mirror = new();
	int cycle_count = 0;

	sorted_priority_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.RANK_WIDTH(RANK_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.item_value(item_value),
		.item_rank(item_rank),
		.done(done),
		.status(status),
		.head_value(head_value),
		.occupancy(occupancy)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_reply(status, head_value, occupancy);
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 45)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// hold the beat until busy is low at a rising edge, then idle for the given gap
	task automatic issue(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] value,
			input logic [RANK_PORT_W-1:0] rank, input int gap);
		func = fn;
		item_value = value;
		item_rank = rank;
		start = 1'b1;
		do @(posedge clk); while (busy);
		mirror.note_command(fn, value, rank);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			func = FUNC_W'($urandom);
			item_value = $urandom;
			item_rank = RANK_PORT_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		int                     n_cmds;
		int                     burst_len;
		bit                     no_idle;
		burst_mix_t             mix;
		int                     p;
		logic [FUNC_W-1:0]      fn;
		logic [VALUE_W-1:0]     value;
		logic [RANK_PORT_W-1:0] rank;

		arst_n = 1'b0;
		start = 1'b0;
		func = FN_INSERT;
		item_value = '0;
		item_rank = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue: peek, remove and the unused code
		issue(FN_PEEK, $urandom, RANK_PORT_W'($urandom), pick_gap());
		issue(FN_REMOVE, $urandom, RANK_PORT_W'($urandom), pick_gap());
		issue(FN_UNUSED, $urandom, RANK_PORT_W'($urandom), pick_gap());
		// extremes, head displacement and equal-rank placement
		issue(FN_INSERT, 32'h8000_0000, 16'hFFFF, pick_gap());
		issue(FN_INSERT, 32'h7FFF_FFFF, 16'h0000, pick_gap());
		issue(FN_INSERT, 32'd1, 16'h0000, pick_gap());
		issue(FN_INSERT, 32'd2, 16'h0000, pick_gap());
		issue(FN_INSERT, 32'd3, 16'hFFFF, pick_gap());
		issue(FN_PEEK, $urandom, RANK_PORT_W'($urandom), pick_gap());
		issue(FN_UNUSED, $urandom, RANK_PORT_W'($urandom), pick_gap());
		repeat (6) issue(FN_REMOVE, $urandom, RANK_PORT_W'($urandom), pick_gap());
		issue(FN_INSERT, 32'h0000_0000, 16'h5555, 0);
		issue(FN_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 0);
		issue(FN_PEEK, $urandom, RANK_PORT_W'($urandom), 0);
		issue(FN_REMOVE, $urandom, RANK_PORT_W'($urandom), pick_gap());
		issue(FN_REMOVE, $urandom, RANK_PORT_W'($urandom), pick_gap());

		// bursts biased to fill, drain or mix so full and empty recur often
		n_cmds = 0;
		while (n_cmds < CMD_TARGET) begin
			burst_len = $urandom_range(10, 60);
			no_idle = ($urandom_range(99) < 20);
			mix = burst_mix_t'($urandom_range(2));
			repeat (burst_len) begin
				p = $urandom_range(99);
				if (p < 4)
					fn = FN_UNUSED;
				else begin
					p = $urandom_range(99);
					case (mix)
						MIX_FILL:  fn = (p < 80) ? FN_INSERT : ((p < 90) ? FN_PEEK : FN_REMOVE);
						MIX_DRAIN: fn = (p < 20) ? FN_INSERT : ((p < 35) ? FN_PEEK : FN_REMOVE);
						default:   fn = (p < 45) ? FN_INSERT : ((p < 65) ? FN_PEEK : FN_REMOVE);
					endcase
				end
				p = $urandom_range(99);
				if (p < 30)
					rank = RANK_PORT_W'($urandom_range(3));
				else if (p < 40)
					rank = ($urandom_range(1) == 0) ? '0 : '1;
				else
					rank = RANK_PORT_W'($urandom);
				p = $urandom_range(99);
				if (p < 5)
					value = 32'h8000_0000;
				else if (p < 10)
					value = 32'h7FFF_FFFF;
				else
					value = $urandom;
				issue(fn, value, rank, no_idle ? 0 : pick_gap());
				if (fn != FN_UNUSED)
					n_cmds++;
			end
		end

		start = 1'b0;
		while (mirror.replies_due.size() != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);

		$display("checked %0d results; peak occupancy %0d of %0d", mirror.n_replies,
			mirror.peak_held, QUEUE_DEPTH);
		$display("inserts refused when full: %0d, remove/peek on empty: %0d",
			mirror.n_full, mirror.n_empty);
		if (mirror.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
